// ----- rtl/core/eabs_pkg.sv -----
// Package for the 3x3 edge-aware box smoothing block.
// Holds widths, codes, the stage tag type, the tap count function and the reciprocal table.
// No dependencies.
package eabs_pkg;

    localparam int SAMPLE_W          = 8;
    localparam int AVG_W             = 16;
    localparam int CFG_W             = 13;
    localparam int CFG_INDEX_W       = 2;
    localparam int ROW_W             = 13;
    localparam int IN_ROW_W          = 14;
    localparam int SUM_W             = 12;
    localparam int NUM_W             = 20;
    localparam int COUNT_W           = 4;
    localparam int RECIP_W           = 25;
    localparam int RECIP_SHIFT       = 24;
    localparam int DEFAULT_MAX_WIDTH = 4096;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 13'd256;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 13'd256;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef struct packed {
        logic emit;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_tag;

    // Number of window taps that lie inside the grid.
    function automatic logic [COUNT_W-1:0] f_count(t_tag tag);
        logic [1:0] rows;
        logic [1:0] cols;
        rows = 2'd1 + {1'b0, tag.top} + {1'b0, tag.bottom};
        cols = 2'd1 + {1'b0, tag.left} + {1'b0, tag.right};
        return {2'b00, rows} * {2'b00, cols};
    endfunction

    // Rounded-up reciprocal of the tap count, scaled by 2**RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] f_recip(logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] recip;
        case (count)
            4'd1:    recip = 25'd16777216;
            4'd2:    recip = 25'd8388608;
            4'd3:    recip = 25'd5592406;
            4'd4:    recip = 25'd4194304;
            4'd6:    recip = 25'd2796203;
            4'd9:    recip = 25'd1864136;
            default: recip = '0;
        endcase
        return recip;
    endfunction

endpackage

// ----- rtl/core/eabs_in_if.sv -----
// Input channel of the box smoothing block: valid, ready and one sample item.
// Depends on eabs_pkg.
interface eabs_in_if import eabs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ----- rtl/core/eabs_out_if.sv -----
// Result channel of the box smoothing block: valid, ready and one result item.
// Depends on eabs_pkg.
interface eabs_out_if import eabs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic             frame_end;

    modport source (output valid, output average, output frame_end, input ready);
    modport sink   (input valid, input average, input frame_end, output ready);
endinterface

// ----- rtl/core/eabs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module eabs_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 4096,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/eabs_front.sv -----
// Input bookkeeping: grid position counters, drain handling, edge flags.
// Loads the first pipeline stage. Depends on eabs_pkg.
module eabs_front import eabs_pkg::*; #(
    parameter int  MAX_WIDTH = DEFAULT_MAX_WIDTH,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int WW        = (CW + 1 > CFG_W) ? CW + 1 : CFG_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [WW-1:0]       i_width,
    input  logic [ROW_W-1:0]    i_height,
    input  logic                i_accept,
    input  logic                i_operation,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_en1,
    output logic [CW-1:0]       o_rd_addr,
    output logic                o_s1_valid,
    output logic [CW-1:0]       o_s1_col,
    output logic [SAMPLE_W-1:0] o_s1_sample,
    output t_tag                o_s1_tag
);

    logic [CW-1:0]       r_in_col, n_in_col;
    logic [IN_ROW_W-1:0] r_in_row, n_in_row;
    logic [CW-1:0]       r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;
    logic                r_s1_valid;
    logic [CW-1:0]       r_s1_col;
    logic [SAMPLE_W-1:0] r_s1_sample;
    t_tag                r_s1_tag;

    logic [IN_ROW_W-1:0] height_ext;
    logic                in_grid;
    logic                take;
    logic [CW-1:0]       col;
    logic [WW-1:0]       col_next;
    logic                wrap;
    t_tag                tag;

    assign height_ext = IN_ROW_W'(i_height);
    assign in_grid    = r_in_row < height_ext;
    assign take       = i_accept && !(i_operation == OP_DRAIN && in_grid);
    assign col        = (WW'(r_in_col) >= i_width) ? '0 : r_in_col;
    assign col_next   = WW'(col) + WW'(1);
    assign wrap       = col_next >= i_width;

    assign tag.emit   = (r_in_row >= IN_ROW_W'(2)) ||
                        (r_in_row == IN_ROW_W'(1) && col != '0);
    assign tag.top    = r_out_row != '0;
    assign tag.bottom = (IN_ROW_W'(r_out_row) + IN_ROW_W'(1)) < height_ext;
    assign tag.left   = r_out_col != '0;
    assign tag.right  = (WW'(r_out_col) + WW'(1)) < i_width;
    assign tag.last   = !tag.bottom && !tag.right;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if (wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_W'(1);
            end else begin
                n_in_col = col_next[CW-1:0];
            end
            if (tag.emit) begin
                if (tag.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (tag.right) begin
                    n_out_col = r_out_col + CW'(1);
                end else begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (i_en1) begin
                r_s1_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_s1_col    <= col;
            r_s1_sample <= in_grid ? i_sample : '0;
            r_s1_tag    <= tag;
        end
    end

    assign o_rd_addr   = col;
    assign o_s1_valid  = r_s1_valid;
    assign o_s1_col    = r_s1_col;
    assign o_s1_sample = r_s1_sample;
    assign o_s1_tag    = r_s1_tag;

endmodule

// ----- rtl/core/eabs_window.sv -----
// Line store update, 3x3 window and masked window sum.
// Holds the second and third pipeline stages. Depends on eabs_pkg.
module eabs_window import eabs_pkg::*; #(
    parameter int  MAX_WIDTH = DEFAULT_MAX_WIDTH,
    localparam int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [CW-1:0]         i_rd_addr,
    input  logic [2*SAMPLE_W-1:0] i_ram_rdata,
    output logic                  o_ram_we,
    output logic [CW-1:0]         o_ram_waddr,
    output logic [2*SAMPLE_W-1:0] o_ram_wdata,
    input  logic                  i_s1_valid,
    input  logic [CW-1:0]         i_s1_col,
    input  logic [SAMPLE_W-1:0]   i_s1_sample,
    input  t_tag                  i_s1_tag,
    input  logic                  i_en2,
    input  logic                  i_en3,
    output logic                  o_s2_valid,
    output logic                  o_s3_valid,
    output logic [NUM_W-1:0]      o_s3_num,
    output logic [COUNT_W-1:0]    o_s3_count,
    output logic                  o_s3_last
);

    logic [SAMPLE_W-1:0]   r_window [9];
    logic                  r_byp_hit;
    logic [2*SAMPLE_W-1:0] r_byp_data;
    logic                  r_s2_valid;
    t_tag                  r_s2_tag;
    logic                  r_s3_valid;
    logic [NUM_W-1:0]      r_s3_num;
    logic [COUNT_W-1:0]    r_s3_count;
    logic                  r_s3_last;

    logic [2*SAMPLE_W-1:0] line;
    logic [2:0]            row_ok;
    logic [2:0]            col_ok;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_W-1:0]    count;
    logic [NUM_W-1:0]      num;

    // The line entry written by the leaving item wins over a read at the same edge.
    assign line        = r_byp_hit ? r_byp_data : i_ram_rdata;
    assign o_ram_we    = i_s1_valid && i_en2;
    assign o_ram_waddr = i_s1_col;
    assign o_ram_wdata = {line[SAMPLE_W-1:0], i_s1_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= o_ram_we && (o_ram_waddr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= o_ram_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_window[i] <= '0;
            end
        end else if (o_ram_we) begin
            for (int r = 0; r < 3; r++) begin
                r_window[3*r]     <= r_window[3*r + 1];
                r_window[3*r + 1] <= r_window[3*r + 2];
            end
            r_window[2] <= line[2*SAMPLE_W-1:SAMPLE_W];
            r_window[5] <= line[SAMPLE_W-1:0];
            r_window[8] <= i_s1_sample;
        end
    end

    assign row_ok = {r_s2_tag.bottom, 1'b1, r_s2_tag.top};
    assign col_ok = {r_s2_tag.right, 1'b1, r_s2_tag.left};

    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (row_ok[r] && col_ok[k]) begin
                    sum = sum + SUM_W'(r_window[3*r + k]);
                end
            end
        end
    end

    assign count = f_count(r_s2_tag);
    assign num   = {sum, 8'h00} + NUM_W'(count >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_en2) begin
                r_s2_valid <= i_s1_valid && i_s1_tag.emit;
            end
            if (i_en3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s2_tag <= i_s1_tag;
        end
        if (i_en3) begin
            r_s3_num   <= num;
            r_s3_count <= count;
            r_s3_last  <= r_s2_tag.last;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s3_valid = r_s3_valid;
    assign o_s3_num   = r_s3_num;
    assign o_s3_count = r_s3_count;
    assign o_s3_last  = r_s3_last;

endmodule

// ----- rtl/core/eabs_scale.sv -----
// Division by the tap count as a reciprocal multiply, and the output register.
// Depends on eabs_pkg.
module eabs_scale import eabs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s3_valid,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_last,
    input  logic               i_ready,
    output logic               o_en_out,
    output logic               o_valid,
    output logic [AVG_W-1:0]   o_average,
    output logic               o_frame_end
);

    localparam int PROD_W = NUM_W + RECIP_W;

    logic               r_valid;
    logic [AVG_W-1:0]   r_average;
    logic               r_frame_end;
    logic [PROD_W-1:0]  product;

    assign product  = PROD_W'(i_num) * PROD_W'(f_recip(i_count));
    assign o_en_out = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en_out) begin
            r_valid <= i_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en_out) begin
            r_average   <= product[RECIP_SHIFT +: AVG_W];
            r_frame_end <= i_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_average   = r_average;
    assign o_frame_end = r_frame_end;

endmodule

// ----- rtl/core/edge_aware_box_smoothing_3x3_top.sv -----
// Top level of the 3x3 edge-aware box smoothing block.
// Depends on eabs_pkg, eabs_in_if, eabs_out_if, eabs_ram, eabs_front,
// eabs_window and eabs_scale.
//
// Usage:
// Samples of a grid_width by grid_height grid arrive in raster order on the
// input channel; drain items follow the last sample to flush the tail.
// Each result on the output channel is the mean of a grid point and its
// neighbors inside the grid, unsigned Q8.8, rounded to nearest; frame_end
// marks the last result of a frame. Results trail their own sample by one
// row plus one sample of the stream.
// One item is taken every clock cycle unless the whole pipeline is full and the
// receiver stalls. A result reaches the output register once the item that
// completes it has passed the pipeline: the input stage with the line store
// read, the window stage, the sum stage and the reciprocal multiply stage.
// Reset sets both sizes to 256 and clears the position counters and the
// window; the line store is not cleared. A register write restarts the frame.
// When the receiver stalls, each stage holds until the one after it frees,
// so the input keeps taking items until the whole pipeline is full.
module edge_aware_box_smoothing_3x3_top import eabs_pkg::*; #(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    eabs_in_if.sink                i_sample_ch,
    eabs_out_if.source             o_result_ch,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CFG_W-1:0]      r_grid_width;
    logic [CFG_W-1:0]      r_grid_height;
    logic [WW-1:0]         width_raw;
    logic [WW-1:0]         width_eff;
    logic [ROW_W-1:0]      height_eff;

    logic                  en1, en2, en3, en_out;
    logic                  accept;
    logic [CW-1:0]         rd_addr;
    logic                  s1_valid;
    logic [CW-1:0]         s1_col;
    logic [SAMPLE_W-1:0]   s1_sample;
    t_tag                  s1_tag;
    logic                  s2_valid;
    logic                  s3_valid;
    logic [NUM_W-1:0]      s3_num;
    logic [COUNT_W-1:0]    s3_count;
    logic                  s3_last;
    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [2*SAMPLE_W-1:0] ram_wdata;
    logic [2*SAMPLE_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RESET;
            r_grid_height <= GRID_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign width_raw  = WW'(r_grid_width);
    assign width_eff  = (r_grid_width == '0)         ? WW'(1) :
                        (width_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_raw;
    assign height_eff = (r_grid_height == '0) ? ROW_W'(1) : r_grid_height;

    assign en3 = !s3_valid || en_out;
    assign en2 = !s2_valid || en3;
    assign en1 = !s1_valid || en2;

    assign i_sample_ch.ready = en1;
    assign accept            = i_sample_ch.valid && en1;

    eabs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_accept    (accept),
        .i_operation (i_sample_ch.operation),
        .i_sample    (i_sample_ch.sample),
        .i_en1       (en1),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1_col    (s1_col),
        .o_s1_sample (s1_sample),
        .o_s1_tag    (s1_tag)
    );

    // Each entry holds the upper line sample over the middle line sample.
    eabs_ram #(
        .WIDTH (2*SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en1),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    eabs_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (en1),
        .i_rd_addr   (rd_addr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_s1_valid  (s1_valid),
        .i_s1_col    (s1_col),
        .i_s1_sample (s1_sample),
        .i_s1_tag    (s1_tag),
        .i_en2       (en2),
        .i_en3       (en3),
        .o_s2_valid  (s2_valid),
        .o_s3_valid  (s3_valid),
        .o_s3_num    (s3_num),
        .o_s3_count  (s3_count),
        .o_s3_last   (s3_last)
    );

    eabs_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s3_valid  (s3_valid),
        .i_num       (s3_num),
        .i_count     (s3_count),
        .i_last      (s3_last),
        .i_ready     (o_result_ch.ready),
        .o_en_out    (en_out),
        .o_valid     (o_result_ch.valid),
        .o_average   (o_result_ch.average),
        .o_frame_end (o_result_ch.frame_end)
    );

    // The input is held off only when every stage is full and the receiver stalls.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample_ch.ready |-> s1_valid && s2_valid && s3_valid &&
                               o_result_ch.valid && !o_result_ch.ready)
        else $error("input held off with a free pipeline stage");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result_ch.valid |-> i_sample_ch.ready)
        else $error("input not ready while the output register is empty");

    a_s3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_valid && en_out |=> o_result_ch.valid)
        else $error("sum stage result lost on its way to the output register");

endmodule
